FILE: src/rrts_pkg.sv
`default_nettype none
package rrts_pkg;
    localparam int MaxTasks = 16;
    localparam int IdW = 4;
    localparam int CntW = 5;
    localparam int TickW = 32;

    typedef enum logic [2:0] {
        OP_YIELD = 3'd0, OP_SUSPEND = 3'd1, OP_RESUME = 3'd2,
        OP_TICK = 3'd3, OP_DELAY = 3'd4, OP_PERIODIC = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        PLACE_NONE = 2'd0, PLACE_READY = 2'd1, PLACE_DELAY = 2'd2
    } place_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  task_id;
        logic [31:0] tick_amount;
        logic [31:0] last_wake;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  running_task;
        logic        switched;
        logic [3:0]  prior_task;
        logic [31:0] tick_now;
        logic [31:0] next_wake;
        logic        slept;
        logic [4:0]  woken_count;
        logic        status;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_PUSH, ST_SCAN, ST_WAKE, ST_YIELD, ST_POP, ST_DONE
    } state_t;

    // controller commands to the datapath
    typedef struct packed {
        logic latch_in;
        logic rtake;
        logic dtake;
        logic push_task;
        logic push_run;
        logic pop_run;
        logic tick_inc;
        logic start_scan;
        logic scan_step;
        logic insert;
        logic wake_step;
        logic set_status;
        logic set_slept;
        logic set_switched;
        logic emit;
    } ctrl_t;

    // datapath status to the controller
    typedef struct packed {
        logic [2:0] op;
        logic       run_eq;
        logic       ready_empty;
        logic       delay_empty;
        logic [1:0] place;
        logic       dist_ok;
        logic       scan_done;
        logic       wake_hit;
    } stat_t;
endpackage
`default_nettype wire

FILE: src/rtos_round_robin_task_scheduler_top.sv
`default_nettype none
// Round-robin task scheduler with a sorted delay list.
// Command channel: drive cmd_word and raise start; the word is taken at a
// rising edge where start is high and busy is low. busy is high from that
// edge until the result cycle, in which it is low again.
// Result channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall it, so it must capture the word in that cycle.
// Path through the controller after the accepting edge: decode, then done,
// for ignored words, suspend of a queued or delayed task, resume of a task in
// no list and suspend of the running task with an empty queue; resume of a
// delayed task passes push, and suspend of the running task pop; yield passes
// yield and, with a non-empty queue, pop; a delay that sleeps passes scan and
// pop; a tick passes wake and yield, then pop as a yield does.
// The delay scan and the wake walk step one entry a cycle. A new word may be
// taken in the done cycle, so one word is in flight at a time.
// Reset: asynchronous active-low; empties both lists, clears the tick
// counter and leaves the idle task 0 running.
module rtos_round_robin_task_scheduler_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire rrts_pkg::in_word_t  cmd_word,
    output logic                     done,
    output rrts_pkg::out_word_t      result
);
    rrts_pkg::ctrl_t cmd;
    rrts_pkg::stat_t st;

    rrts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    rrts_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (cmd_word),
        .cmd      (cmd),
        .st       (st),
        .strobe   (done),
        .out_word (result)
    );
endmodule
`default_nettype wire

FILE: src/rrts_ctrl.sv
`default_nettype none
module rrts_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire rrts_pkg::stat_t st,
    output rrts_pkg::ctrl_t     cmd
);
    rrts_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrts_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != rrts_pkg::ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            rrts_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = rrts_pkg::ST_DECODE;
                end
            end
            rrts_pkg::ST_DECODE:
            begin
                state_next = rrts_pkg::ST_DONE;
                unique case (st.op) inside
                    rrts_pkg::OP_YIELD:
                    begin
                        cmd.set_switched = 1'b1;
                        state_next = rrts_pkg::ST_YIELD;
                    end
                    rrts_pkg::OP_SUSPEND:
                    begin
                        if (st.run_eq)
                        begin
                            if (st.ready_empty)
                                cmd.set_status = 1'b1;
                            else
                            begin
                                cmd.set_switched = 1'b1;
                                state_next = rrts_pkg::ST_POP;
                            end
                        end
                        else if (st.place == rrts_pkg::PLACE_READY)
                            cmd.rtake = 1'b1;
                        else if (st.place == rrts_pkg::PLACE_DELAY)
                            cmd.dtake = 1'b1;
                        else
                            cmd.set_status = 1'b1;
                    end
                    rrts_pkg::OP_RESUME:
                    begin
                        if (st.run_eq || st.place == rrts_pkg::PLACE_READY)
                            cmd.set_status = 1'b1;
                        else if (st.place == rrts_pkg::PLACE_DELAY)
                        begin
                            // early wake: leave the delay list, then queue
                            cmd.dtake = 1'b1;
                            state_next = rrts_pkg::ST_PUSH;
                        end
                        else
                            cmd.push_task = 1'b1;
                    end
                    rrts_pkg::OP_TICK:
                    begin
                        cmd.tick_inc = 1'b1;
                        cmd.set_switched = 1'b1;
                        state_next = rrts_pkg::ST_WAKE;
                    end
                    rrts_pkg::OP_DELAY, rrts_pkg::OP_PERIODIC:
                    begin
                        if (st.dist_ok && !st.ready_empty)
                        begin
                            cmd.start_scan = 1'b1;
                            cmd.set_slept = 1'b1;
                            cmd.set_switched = 1'b1;
                            state_next = rrts_pkg::ST_SCAN;
                        end
                        else
                            cmd.set_status = 1'b1;
                    end
                    default: cmd.set_status = 1'b1;
                endcase
            end
            rrts_pkg::ST_PUSH:
            begin
                cmd.push_task = 1'b1;
                state_next = rrts_pkg::ST_DONE;
            end
            rrts_pkg::ST_SCAN:
            begin
                if (st.scan_done)
                begin
                    cmd.insert = 1'b1;
                    state_next = rrts_pkg::ST_POP;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            rrts_pkg::ST_WAKE:
            begin
                // one woken task per cycle while the front entry is due
                if (!st.delay_empty && st.wake_hit)
                    cmd.wake_step = 1'b1;
                else
                    state_next = rrts_pkg::ST_YIELD;
            end
            rrts_pkg::ST_YIELD:
            begin
                if (!st.ready_empty)
                begin
                    cmd.push_run = 1'b1;
                    state_next = rrts_pkg::ST_POP;
                end
                else
                    state_next = rrts_pkg::ST_DONE;
            end
            rrts_pkg::ST_POP:
            begin
                cmd.pop_run = 1'b1;
                state_next = rrts_pkg::ST_DONE;
            end
            rrts_pkg::ST_DONE:
            begin
                cmd.emit = 1'b1;
                state_next = rrts_pkg::ST_IDLE;
            end
            default: state_next = rrts_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: src/rrts_datapath.sv
`default_nettype none
module rrts_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rrts_pkg::in_word_t  in_word,
    input  wire rrts_pkg::ctrl_t     cmd,
    output rrts_pkg::stat_t          st,
    output logic                     strobe,
    output rrts_pkg::out_word_t      out_word
);
    localparam int N = rrts_pkg::MaxTasks;
    localparam int IW = rrts_pkg::IdW;
    localparam int CW = rrts_pkg::CntW;
    localparam int TW = rrts_pkg::TickW;

    logic [IW-1:0] rq_reg [N];
    logic [IW-1:0] dq_reg [N];
    logic [TW-1:0] wtime_reg [N];
    logic [1:0]    place_reg [N];
    logic [CW-1:0] rcnt_reg, dcnt_reg;
    logic [IW-1:0] run_reg, prior_reg;
    logic [TW-1:0] tick_reg;
    logic [2:0]    op_reg;
    logic [IW-1:0] tid_reg;     // task addressed by the word
    logic [TW-1:0] amt_reg, last_reg;
    logic [CW-1:0] idx_reg;     // scan index, insert place
    logic          sw_reg, sl_reg, stat_reg;
    logic [CW-1:0] woken_reg;
    logic          strobe_reg;
    rrts_pkg::out_word_t out_reg;

    logic [TW-1:0] wake_val, wake_dist, edist, nwake;
    logic [IW-1:0] idx_s;
    logic [IW-1:0] rq_rm [N];
    logic [IW-1:0] dq_rm [N];
    logic [IW-1:0] dq_ins [N];
    logic          r_seen, d_seen;

    assign idx_s     = idx_reg[IW-1:0];
    assign nwake     = last_reg + amt_reg;
    assign wake_val  = (op_reg == rrts_pkg::OP_PERIODIC) ? nwake : (tick_reg + amt_reg);
    assign wake_dist = wake_val - tick_reg;
    assign edist     = wtime_reg[dq_reg[idx_s]] - tick_reg;

    // ready queue with the addressed task taken out
    always_comb
    begin
        r_seen = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if ((CW'(i) < rcnt_reg) && (rq_reg[i] == tid_reg))
                r_seen = 1'b1;
            rq_rm[i] = r_seen ? rq_reg[(i + 1) % N] : rq_reg[i];
        end
    end

    // delay list with the addressed task taken out
    always_comb
    begin
        d_seen = 1'b0;
        for (int i = 0; i < N; i++)
        begin
            if ((CW'(i) < dcnt_reg) && (dq_reg[i] == tid_reg))
                d_seen = 1'b1;
            dq_rm[i] = d_seen ? dq_reg[(i + 1) % N] : dq_reg[i];
        end
    end

    // delay list with the running task placed at the scan index
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (CW'(i) < idx_reg)
                dq_ins[i] = dq_reg[i];
            else if (CW'(i) == idx_reg)
                dq_ins[i] = run_reg;
            else
                dq_ins[i] = dq_reg[(i + N - 1) % N];
        end
    end

    // status to controller
    always_comb
    begin
        st.op          = op_reg;
        st.run_eq      = (tid_reg == run_reg);
        st.ready_empty = (rcnt_reg == '0);
        st.delay_empty = (dcnt_reg == '0);
        st.place       = place_reg[tid_reg];
        st.dist_ok     = (wake_dist != '0) && (wake_dist <= amt_reg);
        st.scan_done   = (idx_reg >= dcnt_reg) || (edist > wake_dist);
        st.wake_hit    = (wtime_reg[dq_reg[0]] == tick_reg);
    end

    // scheduler state, at most one list update a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcnt_reg   <= '0;
            dcnt_reg   <= '0;
            run_reg    <= '0;
            tick_reg   <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < N; i++)
                place_reg[i] <= rrts_pkg::PLACE_NONE;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.tick_inc)
                tick_reg <= tick_reg + TW'(1);
            if (cmd.rtake)
            begin
                for (int i = 0; i < N; i++)
                    rq_reg[i] <= rq_rm[i];
                if (r_seen)
                    rcnt_reg <= rcnt_reg - CW'(1);
                place_reg[tid_reg] <= rrts_pkg::PLACE_NONE;
            end
            else if (cmd.dtake)
            begin
                for (int i = 0; i < N; i++)
                    dq_reg[i] <= dq_rm[i];
                if (d_seen)
                    dcnt_reg <= dcnt_reg - CW'(1);
                place_reg[tid_reg] <= rrts_pkg::PLACE_NONE;
            end
            else if (cmd.push_task)
            begin
                if (rcnt_reg != CW'(N))
                begin
                    rq_reg[rcnt_reg[IW-1:0]] <= tid_reg;
                    place_reg[tid_reg] <= rrts_pkg::PLACE_READY;
                    rcnt_reg <= rcnt_reg + CW'(1);
                end
            end
            else if (cmd.push_run)
            begin
                if (rcnt_reg != CW'(N))
                begin
                    rq_reg[rcnt_reg[IW-1:0]] <= run_reg;
                    place_reg[run_reg] <= rrts_pkg::PLACE_READY;
                    rcnt_reg <= rcnt_reg + CW'(1);
                end
            end
            else if (cmd.pop_run)
            begin
                // head of the queue starts running
                run_reg <= rq_reg[0];
                for (int i = 0; i < N - 1; i++)
                    rq_reg[i] <= rq_reg[i + 1];
                rcnt_reg <= rcnt_reg - CW'(1);
                place_reg[rq_reg[0]] <= rrts_pkg::PLACE_NONE;
            end
            else if (cmd.wake_step)
            begin
                // front of the delay list moves to the queue tail, or drops out if the queue is full
                for (int i = 0; i < N - 1; i++)
                    dq_reg[i] <= dq_reg[i + 1];
                dcnt_reg <= dcnt_reg - CW'(1);
                if (rcnt_reg != CW'(N))
                begin
                    rq_reg[rcnt_reg[IW-1:0]] <= dq_reg[0];
                    place_reg[dq_reg[0]] <= rrts_pkg::PLACE_READY;
                    rcnt_reg <= rcnt_reg + CW'(1);
                end
                else
                    place_reg[dq_reg[0]] <= rrts_pkg::PLACE_NONE;
            end
            else if (cmd.insert)
            begin
                for (int i = 0; i < N; i++)
                    dq_reg[i] <= dq_ins[i];
                wtime_reg[run_reg] <= wake_val;
                place_reg[run_reg] <= rrts_pkg::PLACE_DELAY;
                dcnt_reg <= dcnt_reg + CW'(1);
            end
        end
    end

    // word registers, flags and scan index
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_word.operation;
            tid_reg   <= in_word.task_id;
            amt_reg   <= in_word.tick_amount;
            last_reg  <= in_word.last_wake;
            prior_reg <= run_reg;
            sw_reg    <= 1'b0;
            sl_reg    <= 1'b0;
            stat_reg  <= 1'b0;
            woken_reg <= '0;
        end
        if (cmd.set_switched)
            sw_reg <= 1'b1;
        if (cmd.set_slept)
            sl_reg <= 1'b1;
        if (cmd.set_status)
            stat_reg <= 1'b1;
        if (cmd.wake_step)
            woken_reg <= woken_reg + CW'(1);
        if (cmd.start_scan)
            idx_reg <= '0;
        else if (cmd.scan_step)
            idx_reg <= idx_reg + CW'(1);
        if (cmd.emit)
        begin
            out_reg.running_task <= run_reg;
            out_reg.switched     <= sw_reg;
            out_reg.prior_task   <= prior_reg;
            out_reg.tick_now     <= tick_reg;
            out_reg.next_wake    <= (op_reg == rrts_pkg::OP_PERIODIC) ? nwake : '0;
            out_reg.slept        <= sl_reg;
            out_reg.woken_count  <= woken_reg;
            out_reg.status       <= stat_reg;
        end
    end

    assign strobe   = strobe_reg;
    assign out_word = out_reg;
endmodule
`default_nettype wire

FILE: src/rrts_checker.sv
`default_nettype none
module rrts_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);
    // the result word shows once the block is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    // done lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // busy only drops with a result word
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done) else $error("busy dropped without done");
    // accepted word makes the block busy
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("start lost");
endmodule

bind rtos_round_robin_task_scheduler_top rrts_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done)
);
`default_nettype wire
